### rtl/core/slt_pkg.sv
// Package for the sorted list table: sizes, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 5;

  localparam logic [KIND_W-1:0] KIND_ORDERED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HEAD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAIL    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } slt_cmd_t;

  typedef struct packed {
    logic out_busy;
  } slt_sts_t;

endpackage

### rtl/core/sorted_list_table.sv
// Sorted list table: ordered store of up to CAPACITY signed 32-bit keys with
// insert ordered / head / tail, remove and search. Uses slt_pkg, slt_ctrl, slt_dp.
//
// Each accepted word is handled in order: first the operation is captured,
// then all held keys are compared in parallel, the first match or first
// greater key is picked and the key row shifts. One operation is in flight at
// a time since the next one depends on the updated row; a new word is taken
// while the previous result still waits in the output register. If that
// result is not taken, the update stalls until it is. Status and count come
// back with every word; inserts into a full table are dropped with a full status.
module sorted_list_table import slt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] position, [9:5] count, [15:10] zero
  output logic [2:0]  m_axis_tuser    // [1:0] status, [2] found
);

  slt_cmd_t          cmd;
  slt_sts_t          sts;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  count;

  slt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (s_axis_tuser),
    .key_i       (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .found_o     (found),
    .position_o  (position),
    .count_o     (count)
  );

  assign m_axis_tdata = {6'd0, count, position};
  assign m_axis_tuser = {found, status};

endmodule

### rtl/core/slt_ctrl.sv
// Controller of the sorted list table: two-state sequencer that accepts a
// word, then fires the update once the result register is free. Uses slt_pkg.
module slt_ctrl import slt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  slt_sts_t sts_i,
  output slt_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = (state_q == ST_IDLE);
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/slt_dp.sv
// Datapath of the sorted list table: row of key cells with parallel compare,
// priority pick, shift update and the result register. Uses slt_pkg.
module slt_dp import slt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slt_cmd_t          cmd_i,
  output slt_sts_t          sts_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic              found_o,
  output logic [POS_W-1:0]  position_o,
  output logic [POS_W-1:0]  count_o
);

  logic [KIND_W-1:0] kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  cells_q [CAPACITY];
  logic [KEY_W-1:0]  cells_d [CAPACITY];
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic [CAPACITY-1:0] eq_v, gt_v;
  logic [CNT_W-1:0]    hit_pos, gt_pos, ins_pos;
  logic                hit_any, gt_any, full, is_ins;

  always_comb begin
    eq_v    = '0;
    gt_v    = '0;
    hit_pos = '0;
    gt_pos  = cnt_q;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) < cnt_q) begin
        eq_v[i] = (cells_q[i] == key_q);
        gt_v[i] = ($signed(cells_q[i]) > $signed(key_q));
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (eq_v[i]) hit_pos = CNT_W'(i);
      if (gt_v[i]) gt_pos = CNT_W'(i);
    end
  end

  assign hit_any = |eq_v;
  assign gt_any  = |gt_v;
  assign full    = (cnt_q >= CNT_W'(CAPACITY));
  assign is_ins  = (kind_q == KIND_ORDERED) || (kind_q == KIND_HEAD) ||
                   (kind_q == KIND_TAIL);

  always_comb begin
    case (kind_q)
      KIND_ORDERED: ins_pos = gt_any ? gt_pos : cnt_q;
      KIND_HEAD:    ins_pos = '0;
      default:      ins_pos = cnt_q;
    endcase
  end

  always_comb begin
    cells_d  = cells_q;
    cnt_d    = cnt_q;
    status_d = STAT_OK;
    found_d  = 1'b0;
    pos_d    = '0;
    if (is_ins) begin
      if (full) begin
        status_d = STAT_FULL;
      end else begin
        pos_d = POS_W'(ins_pos);
        cnt_d = cnt_q + CNT_W'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == ins_pos) begin
            cells_d[i] = key_q;
          end else if (i > 0 && CNT_W'(i) > ins_pos) begin
            cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end else if (kind_q == KIND_REMOVE || kind_q == KIND_SEARCH) begin
      if (!hit_any) begin
        status_d = STAT_MISSING;
      end else begin
        found_d = 1'b1;
        pos_d   = POS_W'(hit_pos);
        if (kind_q == KIND_REMOVE) begin
          cnt_d = cnt_q - CNT_W'(1);
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CNT_W'(i) >= hit_pos) cells_d[i] = cells_q[i + 1];
          end
        end
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      key_q  <= key_i;
    end
    if (cmd_i.exec) begin
      cells_q  <= cells_d;
      status_q <= status_d;
      found_q  <= found_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign position_o     = pos_q;
  assign count_o        = POS_W'(cnt_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && is_ins && full |=> cnt_q == $past(cnt_q))
    else $error("insert into full table changed count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !sts_o.out_busy)
    else $error("update fired while result still pending");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.exec))
    else $error("result valid without an update");

endmodule

### bench/sorted_list_table_test.sv
// Self-checking bench for sorted_list_table: directed table then random words,
// with each result word checked against the plan's expected result or a predictor of the key store.
// Depends on slt_pkg and the sorted_list_table RTL.
`timescale 1ns / 100ps

module sorted_list_table_test;
  import slt_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_WORDS = 650;
  localparam int          TAIL_CYCLES  = 16;
  localparam logic [2:0]  KIND_SPARE_LO = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  count;
  } outcome_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic              exact;
    outcome_t          want;
  } plan_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [31:0] key
  logic [2:0]  s_axis_tuser = '0;  // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // [4:0] position, [9:5] count, [15:10] zero
  logic [2:0]  m_axis_tuser;       // [1:0] status, [2] found

  logic signed [KEY_W-1:0] stored_keys [CAPACITY];
  int       stored_count = 0;
  outcome_t pending_results [$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       burst_left = 0;

  rx_mode_e rx_mode = RX_OPEN;
  logic [7:0] rx_pattern = 8'hFF;
  int       rx_left = 0;
  logic [2:0] rx_phase = '0;

  // directed words; exact rows carry their expected result
  plan_row_t plan [26] = '{
    '{KIND_SEARCH,   32'd0,       1'b1, '{STAT_MISSING, 1'b0, 5'd0, 5'd0}},
    '{KIND_REMOVE,   KEY_MIN,     1'b1, '{STAT_MISSING, 1'b0, 5'd0, 5'd0}},
    '{KIND_ORDERED,  32'd7,       1'b1, '{STAT_OK,      1'b0, 5'd0, 5'd1}},
    '{KIND_REMOVE,   32'd7,       1'b1, '{STAT_OK,      1'b1, 5'd0, 5'd0}},
    '{KIND_SPARE_LO, 32'd7,       1'b1, '{STAT_OK,      1'b0, 5'd0, 5'd0}},
    '{KIND_ORDERED,  KEY_MAX,     1'b1, '{STAT_OK,      1'b0, 5'd0, 5'd1}},
    '{KIND_ORDERED,  KEY_MIN,     1'b1, '{STAT_OK,      1'b0, 5'd0, 5'd2}},
    '{KIND_HEAD,     32'hFFFF_FFFF, 1'b1, '{STAT_OK,    1'b0, 5'd0, 5'd3}},
    '{KIND_TAIL,     32'd0,       1'b1, '{STAT_OK,      1'b0, 5'd3, 5'd4}},
    '{KIND_ORDERED,  32'd0,       1'b0, '0},
    '{KIND_SEARCH,   32'd0,       1'b0, '0},
    '{KIND_ORDERED,  32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_SPARE_HI, KEY_MAX,     1'b0, '0},
    '{KIND_ORDERED,  32'd5,       1'b0, '0},
    '{KIND_HEAD,     32'd100,     1'b0, '0},
    '{KIND_TAIL,     32'hFFFF_FF9C, 1'b0, '0},
    '{KIND_ORDERED,  32'd3,       1'b0, '0},
    '{KIND_ORDERED,  32'd5,       1'b0, '0},
    '{KIND_HEAD,     32'h1234_5678, 1'b0, '0},
    '{KIND_TAIL,     32'hDEAD_BEEF, 1'b0, '0},
    '{KIND_ORDERED,  32'hFFFF_FFF9, 1'b0, '0},
    '{KIND_ORDERED,  32'd1,       1'b0, '0},
    '{KIND_TAIL,     32'd2,       1'b0, '0},
    '{KIND_ORDERED,  32'd9,       1'b1, '{STAT_FULL,    1'b0, 5'd0, 5'd16}},
    '{KIND_HEAD,     KEY_MIN,     1'b1, '{STAT_FULL,    1'b0, 5'd0, 5'd16}},
    '{KIND_TAIL,     KEY_MAX,     1'b1, '{STAT_FULL,    1'b0, 5'd0, 5'd16}}
  };

  sorted_list_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // updates the key store and returns the result word it owes
  function automatic outcome_t apply_op(input logic [KIND_W-1:0] kind,
                                        input logic signed [KEY_W-1:0] key);
    outcome_t res;
    int       slot;
    bit       hit;
    res = '0;
    res.status = STAT_OK;
    case (kind)
      KIND_ORDERED, KIND_HEAD, KIND_TAIL: begin
        if (stored_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          slot = (kind == KIND_HEAD) ? 0 : stored_count;
          if (kind == KIND_ORDERED) begin
            for (int i = 0; i < stored_count; i++) begin
              if (stored_keys[i] > key) begin
                slot = i;
                break;
              end
            end
          end
          for (int i = stored_count; i > slot; i--) stored_keys[i] = stored_keys[i-1];
          stored_keys[slot] = key;
          stored_count++;
          res.position = POS_W'(slot);
        end
      end
      KIND_REMOVE, KIND_SEARCH: begin
        hit = 1'b0;
        slot = 0;
        for (int i = 0; i < stored_count; i++) begin
          if (stored_keys[i] == key) begin
            hit = 1'b1;
            slot = i;
            break;
          end
        end
        if (!hit) begin
          res.status = STAT_MISSING;
        end else begin
          res.found = 1'b1;
          res.position = POS_W'(slot);
          if (kind == KIND_REMOVE) begin
            for (int i = slot; i + 1 < stored_count; i++) stored_keys[i] = stored_keys[i+1];
            stored_count--;
          end
        end
      end
      default: ;
    endcase
    res.count = POS_W'(stored_count);
    return res;
  endfunction

  // mostly held keys or a narrow pool of small keys so removes and searches hit
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && stored_count > 0) return stored_keys[$urandom_range(0, stored_count - 1)];
    if (r < 7) return KEY_W'($urandom_range(0, 8)) - KEY_W'(4);
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic put_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                          input logic exact, input outcome_t want);
    outcome_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_op(kind, key);
    pending_results.push_back(exact ? want : predicted);
  endtask

  // end of burst: gap, or with drain set hold off until all results are back
  task automatic after_word(input bit drain);
    if (drain || burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      if (drain) begin
        do @(posedge clk_i); while (pending_results.size() != 0);
      end else begin
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 3));
      rx_pattern = 8'($urandom()) | 8'h01;
      rx_left    = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    rx_phase = rx_phase + 3'd1;
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PATTERN: m_axis_tready <= rx_pattern[rx_phase];
      default:    m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status   = m_axis_tuser[1:0];
      got.found    = m_axis_tuser[2];
      got.position = m_axis_tdata[4:0];
      got.count    = m_axis_tdata[9:5];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, count", got.count, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.found != want.found) report_mismatch("found", got.found, want.found);
        if (got.position != want.position)
          report_mismatch("position", got.position, want.position);
        if (got.count != want.count) report_mismatch("count", got.count, want.count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sorted_list_table");
      $finish;
    end
  end

  initial begin
    logic [KIND_W-1:0] kind;
    int                insert_pct;
    insert_pct = 50;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(0, 12);
    foreach (plan[i]) begin
      put_word(plan[i].kind, plan[i].key, plan[i].exact, plan[i].want);
      after_word(i == $size(plan) - 1);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // swing between filling and draining so full and empty both recur
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      if ($urandom_range(0, 99) < 4)
        kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if ($urandom_range(0, 99) < insert_pct)
        kind = KIND_W'($urandom_range(KIND_ORDERED, KIND_TAIL));
      else
        kind = KIND_W'($urandom_range(KIND_REMOVE, KIND_SEARCH));
      put_word(kind, pick_key(), 1'b0, '0);
      after_word(n == RANDOM_WORDS / 2 || n == RANDOM_WORDS - 1);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS sorted_list_table");
    end else begin
      $display("FAIL sorted_list_table");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/slt_pkg.sv
rtl/core/slt_ctrl.sv
rtl/core/slt_dp.sv
rtl/core/sorted_list_table.sv
bench/sorted_list_table_test.sv
